FILE: rtl/ptt_pkg.sv
// Package: types, constants and codes shared by the port trigger table.
package ptt_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam logic [15:0] TIMEOUT_RESET = 16'd120;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   // commands
   localparam logic [2:0] CMD_OUTBOUND = 3'd0;
   localparam logic [2:0] CMD_CHECK    = 3'd1;
   localparam logic [2:0] CMD_DNAT     = 3'd2;
   localparam logic [2:0] CMD_TICK     = 3'd3;
   localparam logic [2:0] CMD_FLUSH    = 3'd4;

   // verdicts
   localparam logic [1:0] VERDICT_CONTINUE = 2'd0;
   localparam logic [1:0] VERDICT_ACCEPT   = 2'd1;
   localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

   // rule protocols
   localparam logic [1:0] RULE_TCP  = 2'd0;
   localparam logic [1:0] RULE_UDP  = 2'd1;
   localparam logic [1:0] RULE_BOTH = 2'd2;

   // register indexes
   localparam logic [0:0] REG_TIMEOUT = 1'd0;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  ip_proto;
      logic [15:0] dst_port;
      logic [31:0] src_ip;
      logic [1:0]  rule_proto;
      logic [15:0] match_low;
      logic [15:0] match_high;
      logic [15:0] relate_low;
      logic [15:0] relate_high;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [31:0] nat_ip;
      logic        table_full;
   } rsp_type;

   // one slot as stored in memory
   typedef struct packed {
      logic [1:0]  proto;
      logic [15:0] match_low;
      logic [15:0] match_high;
      logic [15:0] relate_low;
      logic [15:0] relate_high;
      logic [31:0] host_ip;
      logic        reply_seen;
      logic [15:0] ticks_left;
      logic [31:0] stamp;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   function automatic logic proto_hits(input logic [1:0] rp, input logic [7:0] pkt);
      logic r;
      r = 1'b0;
      unique case (rp)
         RULE_BOTH: r = 1'b1;
         RULE_TCP:  r = (pkt == PROTO_TCP);
         RULE_UDP:  r = (pkt == PROTO_UDP);
         default:   r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/ptt_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module ptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/ptt_engine.sv
// Scan sequencer: reads slots one per cycle, picks the newest hit, writes back.
module ptt_engine #(
   parameter int ENTRIES = ptt_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ptt_pkg::req_type  req_data,
   input  logic [15:0]       timeout_ticks,
   output logic              busy,
   output logic              rsp_valid,
   output ptt_pkg::rsp_type  rsp_data
);

   localparam int AW = $clog2(ENTRIES > 1 ? ENTRIES : 2);
   localparam int CW = $clog2(ENTRIES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_TICK  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;   // next address to read
   logic [CW-1:0] ev_cnt_ff, ev_cnt_in;   // index of data now on rd_data
   logic          ev_ok_ff, ev_ok_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]   counter_ff, counter_in;
   ptt_pkg::req_type req_ff, req_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0]   hit_age_ff, hit_age_in;
   ptt_pkg::slot_type hit_slot_ff, hit_slot_in;
   ptt_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   ptt_pkg::slot_type wr_slot, rd_slot;
   logic [ptt_pkg::SLOT_W-1:0] rd_raw;

   ptt_ram #(.WIDTH(ptt_pkg::SLOT_W), .DEPTH(ENTRIES)) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_slot),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );
   assign rd_slot = ptt_pkg::slot_type'(rd_raw);

   logic use_relate, match, free_any;
   logic [15:0] lo, hi;
   logic [31:0] age;
   logic [AW-1:0] ev_idx, free_idx;

   assign use_relate = (req_ff.cmd != ptt_pkg::CMD_OUTBOUND);
   assign ev_idx = ev_cnt_ff[AW-1:0];
   // slot 0 is read while idle so it is on rd_data right after the accept
   assign rd_addr = (state_ff == ST_IDLE) ? '0 : rd_cnt_ff[AW-1:0];
   assign lo = use_relate ? rd_slot.relate_low : rd_slot.match_low;
   assign hi = use_relate ? rd_slot.relate_high : rd_slot.match_high;
   assign age = counter_ff - rd_slot.stamp;
   assign match = ev_ok_ff && valid_ff[ev_idx]
               && ptt_pkg::proto_hits(rd_slot.proto, req_ff.ip_proto)
               && (req_ff.dst_port >= lo) && (req_ff.dst_port <= hi);

   // lowest free slot, priority over the valid bits
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   // next state and datapath
   always_comb begin
      state_in    = state_ff;
      rd_cnt_in   = rd_cnt_ff;
      ev_cnt_in   = rd_cnt_ff;
      ev_ok_in    = 1'b0;
      valid_in    = valid_ff;
      counter_in  = counter_ff;
      req_in      = req_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_age_in  = hit_age_ff;
      hit_slot_in = hit_slot_ff;
      rsp_in      = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = hit_idx_ff;
      wr_slot     = hit_slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in    = req_data;
               hit_in    = 1'b0;
               hit_age_in = '0;
               rd_cnt_in = '0;
               rsp_in    = '0;
               if (req_data.cmd == ptt_pkg::CMD_FLUSH) begin
                  valid_in = '0;
                  state_in = ST_DONE;
               end else if (req_data.cmd == ptt_pkg::CMD_TICK) begin
                  rd_cnt_in = CW'(1);
                  ev_cnt_in = '0;
                  ev_ok_in  = 1'b1;
                  state_in  = ST_TICK;
               end else if ((req_data.cmd == ptt_pkg::CMD_OUTBOUND
                          || req_data.cmd == ptt_pkg::CMD_CHECK
                          || req_data.cmd == ptt_pkg::CMD_DNAT)
                          && (req_data.ip_proto == ptt_pkg::PROTO_TCP
                          ||  req_data.ip_proto == ptt_pkg::PROTO_UDP)) begin
                  rd_cnt_in = CW'(1);
                  ev_cnt_in = '0;
                  ev_ok_in  = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (match && (!hit_ff || age < hit_age_ff)) begin
               hit_in      = 1'b1;
               hit_idx_in  = ev_idx;
               hit_age_in  = age;
               hit_slot_in = rd_slot;
            end
            if (rd_cnt_ff < CW'(ENTRIES)) begin
               rd_cnt_in = rd_cnt_ff + CW'(1);
               ev_ok_in  = 1'b1;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_DONE;
            unique case (req_ff.cmd)
               ptt_pkg::CMD_OUTBOUND: begin
                  if (hit_ff) begin
                     wr_en = 1'b1;
                     wr_slot.ticks_left = timeout_ticks;
                     if (hit_slot_ff.reply_seen) wr_slot.host_ip = req_ff.src_ip;
                  end else if (!free_any) begin
                     rsp_in.table_full = 1'b1;
                  end else begin
                     wr_en = 1'b1;
                     wr_addr = free_idx;
                     wr_slot.proto = req_ff.rule_proto;
                     wr_slot.match_low = req_ff.match_low;
                     wr_slot.match_high = (req_ff.match_high != '0)
                                        ? req_ff.match_high : req_ff.match_low;
                     wr_slot.relate_low = req_ff.relate_low;
                     wr_slot.relate_high = (req_ff.relate_high != '0)
                                         ? req_ff.relate_high : req_ff.relate_low;
                     wr_slot.host_ip = req_ff.src_ip;
                     wr_slot.reply_seen = 1'b0;
                     wr_slot.ticks_left = timeout_ticks;
                     wr_slot.stamp = counter_ff;
                     valid_in[free_idx] = 1'b1;
                     counter_in = counter_ff + 32'd1;
                  end
               end
               ptt_pkg::CMD_CHECK: begin
                  if (hit_ff) begin
                     wr_en = 1'b1;
                     wr_slot.ticks_left = timeout_ticks;
                     rsp_in.verdict = ptt_pkg::VERDICT_ACCEPT;
                  end
               end
               default: begin
                  if (hit_ff && hit_slot_ff.host_ip != '0) begin
                     wr_en = 1'b1;
                     wr_slot.reply_seen = 1'b1;
                     rsp_in.verdict = ptt_pkg::VERDICT_REDIRECT;
                     rsp_in.nat_ip = hit_slot_ff.host_ip;
                  end
               end
            endcase
         end
         ST_TICK: begin
            // read-modify-write of the slot read last cycle
            wr_addr = ev_idx;
            wr_slot = rd_slot;
            if (ev_ok_ff && valid_ff[ev_idx]) begin
               wr_en = 1'b1;
               if (rd_slot.ticks_left <= 16'd1) begin
                  wr_slot.ticks_left = '0;
                  valid_in[ev_idx] = 1'b0;
               end else begin
                  wr_slot.ticks_left = rd_slot.ticks_left - 16'd1;
               end
            end
            if (rd_cnt_ff < CW'(ENTRIES)) begin
               rd_cnt_in = rd_cnt_ff + CW'(1);
               ev_ok_in  = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         ev_ok_ff     <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
         ev_ok_ff     <= ev_ok_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff   <= rd_cnt_in;
      ev_cnt_ff   <= ev_cnt_in;
      req_ff      <= req_in;
      hit_idx_ff  <= hit_idx_in;
      hit_age_ff  <= hit_age_in;
      hit_slot_ff <= hit_slot_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // a response only follows the done state
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ST_DONE)
      else $error("response without done state");
   // full flag never with a verdict other than continue
   a_full_continue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.table_full |-> rsp_ff.verdict == ptt_pkg::VERDICT_CONTINUE)
      else $error("full with non-continue verdict");
   // an insert sets exactly one more valid bit
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      counter_ff != $past(counter_ff) && !$past(reset)
      |-> $countones(valid_ff) == $countones($past(valid_ff)) + 1)
      else $error("insert without new valid slot");
   // memory writes only in write or tick state
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_WRITE || state_ff == ST_TICK)
      else $error("stray memory write");
`endif

endmodule

FILE: rtl/port_trigger_table_core.sv
// Top level: configuration registers and the slot scan engine.
//
// channel  direction  handshake             payload
// req      in         start & !busy         ptt_pkg::req_type
// rsp      out        rsp_valid, 1 cycle    ptt_pkg::rsp_type
// csr      in/out     APB, pready tied high timeout_ticks at 0x0
//
// A packet scans one slot per cycle from the single-read slot memory, then
// writes back before its response strobe; a tick decrements each valid slot's
// timer in turn, and a flush or an ignored command goes straight to the strobe.
// busy falls with the strobe, so the next start can be taken at the edge that
// ends it. Reset is synchronous, active high; it clears all valid bits at once
// and loads timeout_ticks with 120.
// The receiver cannot stall: the response strobe lasts one cycle.
module port_trigger_table_core #(
   parameter int ENTRIES = ptt_pkg::ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ptt_pkg::req_type req_data,
   output logic             rsp_valid,
   output ptt_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [15:0] timeout_ff, timeout_in;
   logic        sel_timeout;

   assign sel_timeout = (csr_paddr[2] == ptt_pkg::REG_TIMEOUT) && (csr_paddr[1:0] == 2'd0);

   // timeout register write
   always_comb begin
      timeout_in = timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_timeout) begin
         timeout_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ptt_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = sel_timeout ? {16'd0, timeout_ff} : 32'd0;

   ptt_engine #(.ENTRIES(ENTRIES)) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_data     (req_data),
      .timeout_ticks(timeout_ff),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

endmodule
